// File: rtl/slt_pkg.sv
// Shared types, constants and codes of the shifting list table.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int FIDX_W  = 4;
    localparam int ECNT_W  = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_DELETE = 3'd3,
        OP_REMOVE = 3'd4,
        OP_FIND   = 3'd5,
        OP_READ   = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [FIDX_W-1:0]  found_index;
        logic               hit;
        logic [ECNT_W-1:0]  entry_count;
        logic [STAT_W-1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [IDX_W-1:0]     raddr;
    } t_ram_req;

endpackage

// File: rtl/slt_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module slt_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/slt_ctrl.sv
// Sequencer that walks the list through the RAM port and compares or moves one entry per step.
`timescale 1ns / 1ps

module slt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  slt_pkg::t_in_item             i_in_data,
    output logic                          o_in_stall,
    output logic                          o_res_valid,
    output slt_pkg::t_out_item            o_res_data,
    input  logic                          i_res_stall,
    output slt_pkg::t_ram_req             o_ram,
    input  logic [slt_pkg::WORD_BITS-1:0] i_ram_rdata
);

    slt_pkg::t_state                r_state, n_state;
    logic [slt_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    slt_pkg::t_op                   r_mode, n_mode;
    logic [slt_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic [slt_pkg::WORD_BITS-1:0]  r_val, n_val;
    logic [slt_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic [slt_pkg::CNT_W-1:0]      r_wr, n_wr;
    logic [slt_pkg::WORD_BITS-1:0]  r_rv, n_rv;
    logic [slt_pkg::IDX_W-1:0]      r_fidx, n_fidx;
    logic                           r_hit, n_hit;
    slt_pkg::t_status               r_status, n_status;

    logic [slt_pkg::CNT_W-1:0]      in_pos;
    logic [slt_pkg::WORD_BITS-1:0]  in_val;
    logic [slt_pkg::CNT_W-1:0]      idx_inc, idx_dec, wr_inc, cnt_inc, cnt_dec;
    logic                           list_full, list_empty, last_step, match;

    assign in_pos     = slt_pkg::CNT_W'(i_in_data.position);
    assign in_val     = i_in_data.item_value[slt_pkg::WORD_BITS-1:0];
    assign idx_inc    = r_idx + slt_pkg::CNT_W'(1);
    assign idx_dec    = r_idx - slt_pkg::CNT_W'(1);
    assign wr_inc     = r_wr + slt_pkg::CNT_W'(1);
    assign cnt_inc    = r_cnt + slt_pkg::CNT_W'(1);
    assign cnt_dec    = r_cnt - slt_pkg::CNT_W'(1);
    assign list_full  = (r_cnt >= slt_pkg::CNT_W'(slt_pkg::DEPTH));
    assign list_empty = (r_cnt == '0);
    assign last_step  = (idx_inc == r_cnt);
    assign match      = (i_ram_rdata == r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slt_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_rv     <= n_rv;
        r_fidx   <= n_fidx;
        r_hit    <= n_hit;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_val       = r_val;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_rv        = r_rv;
        n_fidx      = r_fidx;
        n_hit       = r_hit;
        n_status    = r_status;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_idx[slt_pkg::IDX_W-1:0];
        o_ram.wdata = i_ram_rdata;
        o_ram.raddr = r_idx[slt_pkg::IDX_W-1:0];
        o_res_valid = 1'b0;

        unique case (r_state)
            slt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = slt_pkg::t_op'(i_in_data.mode);
                    n_pos    = in_pos;
                    n_val    = in_val;
                    n_rv     = '0;
                    n_fidx   = '0;
                    n_hit    = 1'b0;
                    n_status = slt_pkg::ST_OK;
                    n_wr     = '0;
                    n_state  = slt_pkg::S_DONE;
                    case (slt_pkg::t_op'(i_in_data.mode))
                        slt_pkg::OP_PUSH: begin
                            if (list_full) begin
                                n_status = slt_pkg::ST_FULL;
                            end else begin
                                n_pos   = r_cnt;
                                n_state = slt_pkg::S_PUT;
                            end
                        end
                        slt_pkg::OP_INSERT: begin
                            if (list_full) begin
                                n_status = slt_pkg::ST_FULL;
                            end else if (in_pos > r_cnt) begin
                                n_status = slt_pkg::ST_RANGE;
                            end else if (in_pos == r_cnt) begin
                                n_state = slt_pkg::S_PUT;
                            end else begin
                                n_idx   = cnt_dec;
                                n_state = slt_pkg::S_RD;
                            end
                        end
                        slt_pkg::OP_POP: begin
                            if (list_empty) begin
                                n_status = slt_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = cnt_dec;
                                n_state = slt_pkg::S_RD;
                            end
                        end
                        slt_pkg::OP_DELETE: begin
                            if (list_empty) begin
                                n_status = slt_pkg::ST_EMPTY;
                            end else if (in_pos >= r_cnt) begin
                                n_status = slt_pkg::ST_RANGE;
                            end else if (in_pos == cnt_dec) begin
                                n_cnt = cnt_dec;
                            end else begin
                                n_idx   = in_pos + slt_pkg::CNT_W'(1);
                                n_state = slt_pkg::S_RD;
                            end
                        end
                        slt_pkg::OP_REMOVE, slt_pkg::OP_FIND: begin
                            if (!list_empty) begin
                                n_idx   = '0;
                                n_state = slt_pkg::S_RD;
                            end
                        end
                        slt_pkg::OP_READ: begin
                            if (list_empty) begin
                                n_status = slt_pkg::ST_EMPTY;
                            end else if (in_pos >= r_cnt) begin
                                n_status = slt_pkg::ST_RANGE;
                            end else begin
                                n_idx   = in_pos;
                                n_state = slt_pkg::S_RD;
                            end
                        end
                        default: begin
                            n_status = slt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            slt_pkg::S_RD: begin
                n_state = slt_pkg::S_EV;
            end
            slt_pkg::S_EV: begin
                n_state = slt_pkg::S_DONE;
                case (r_mode)
                    slt_pkg::OP_INSERT: begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = idx_inc[slt_pkg::IDX_W-1:0];
                        if (r_idx == r_pos) begin
                            n_state = slt_pkg::S_PUT;
                        end else begin
                            n_idx   = idx_dec;
                            n_state = slt_pkg::S_RD;
                        end
                    end
                    slt_pkg::OP_POP: begin
                        n_rv        = i_ram_rdata;
                        o_ram.we    = 1'b1;
                        o_ram.wdata = '0;
                        n_cnt       = cnt_dec;
                    end
                    slt_pkg::OP_DELETE: begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = idx_dec[slt_pkg::IDX_W-1:0];
                        if (last_step) begin
                            n_cnt = cnt_dec;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = slt_pkg::S_RD;
                        end
                    end
                    slt_pkg::OP_REMOVE: begin
                        if (!match) begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_wr[slt_pkg::IDX_W-1:0];
                            n_wr        = wr_inc;
                        end
                        if (last_step) begin
                            n_cnt = match ? r_wr : wr_inc;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = slt_pkg::S_RD;
                        end
                    end
                    slt_pkg::OP_FIND: begin
                        if (match) begin
                            n_hit  = 1'b1;
                            n_fidx = r_idx[slt_pkg::IDX_W-1:0];
                        end else if (!last_step) begin
                            n_idx   = idx_inc;
                            n_state = slt_pkg::S_RD;
                        end
                    end
                    slt_pkg::OP_READ: begin
                        n_rv = i_ram_rdata;
                    end
                    default: begin
                        n_state = slt_pkg::S_DONE;
                    end
                endcase
            end
            slt_pkg::S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_pos[slt_pkg::IDX_W-1:0];
                o_ram.wdata = r_val;
                n_cnt       = cnt_inc;
                n_state     = slt_pkg::S_DONE;
            end
            slt_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (!i_res_stall) begin
                    n_state = slt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall             = (r_state != slt_pkg::S_IDLE);
    assign o_res_data.read_value  = slt_pkg::VALUE_W'(r_rv);
    assign o_res_data.found_index = slt_pkg::FIDX_W'(r_fidx);
    assign o_res_data.hit         = r_hit;
    assign o_res_data.entry_count = slt_pkg::ECNT_W'(r_cnt);
    assign o_res_data.status      = r_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= slt_pkg::CNT_W'(slt_pkg::DEPTH))
        else $error("entry count exceeds the list depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == slt_pkg::S_EV || r_state == slt_pkg::S_PUT))
        else $error("RAM written outside a working step");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slt_pkg::S_IDLE && !i_in_valid) |=> $stable(r_cnt))
        else $error("entry count changed without an operation");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slt_pkg::S_DONE && i_res_stall) |=> r_state == slt_pkg::S_DONE)
        else $error("result dropped while the output register was full");

endmodule

// File: rtl/slt_out_reg.sv
// Output register that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module slt_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  slt_pkg::t_out_item i_res_data,
    output logic               o_res_stall,
    output logic               o_out_valid,
    output slt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic               r_valid, n_valid;
    slt_pkg::t_out_item r_data, n_data;
    logic               load;

    assign o_res_stall = r_valid && i_out_stall;
    assign load        = i_res_valid && !o_res_stall;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (load) begin
            n_valid = 1'b1;
            n_data  = i_res_data;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// File: rtl/shifting_list_table_unit.sv
// Top level of the shifting list table: an ordered list of words kept in a small RAM.
//
// One input transfer carries an operation (push, insert, pop, delete, remove-all, find, read),
// a position and a value; every input transfer yields exactly one output transfer with the
// word read, the find result, the entry count after the operation and a status code.
// Both channels use valid and stall; a transfer happens on a clock edge with valid high
// and stall low.
// An operation with failed checks, deleting the last entry, or remove-all or find on an
// empty list goes straight to the done state, and a push adds one write step; every list
// entry walked by insert, delete, remove-all or find takes a read step to issue the RAM
// read and an evaluate step to compare or move the registered read data, because the list
// has a single read port and a single write port. From the done state the result is
// loaded into the output register.
// The input stalls while an operation is in progress; the next operation is taken while a
// finished result still waits in the output register.
// When the receiver stalls, the result is held in the output register, and a second
// finished result waits in the sequencer until the register frees.
// Reset empties the list and the output register; stored words are not cleared.
`timescale 1ns / 1ps

module shifting_list_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  slt_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output slt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    slt_pkg::t_ram_req             ram_req;
    logic [slt_pkg::WORD_BITS-1:0] ram_rdata;
    logic                          res_valid;
    logic                          res_stall;
    slt_pkg::t_out_item            res_data;

    slt_ram #(
        .ADDR_W (slt_pkg::IDX_W),
        .DATA_W (slt_pkg::WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    slt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_stall (res_stall),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    slt_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_data  (res_data),
        .o_res_stall (res_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: bench/list_table_checker.sv
// Checker for the shifting list table: predicts every result and compares it with the output.
`timescale 1ns / 1ps

module list_table_checker
    import slt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_item i_out_data,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_results_due
);

    logic [WORD_BITS-1:0] shadow_words [DEPTH];
    int                   shadow_len;
    int                   mismatch_total = 0;
    t_out_item            due_replies [$];
    t_out_item            oldest_reply;

    assign o_fail_count = mismatch_total;

    function automatic t_out_item apply_list_op(input t_in_item op_in);
        t_out_item            reply;
        int                   pos;
        int                   idx;
        int                   kept;
        logic [WORD_BITS-1:0] word;
        reply = '0;
        pos   = int'(op_in.position);
        word  = WORD_BITS'(op_in.item_value);
        case (op_in.mode)
            OP_PUSH: begin
                if (shadow_len >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
            end
            OP_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    reply.status = ST_FULL;
                end else if (pos > shadow_len) begin
                    reply.status = ST_RANGE;
                end else begin
                    for (idx = shadow_len; idx > pos; idx--) begin
                        shadow_words[idx] = shadow_words[idx-1];
                    end
                    shadow_words[pos] = word;
                    shadow_len++;
                end
            end
            OP_POP: begin
                if (shadow_len == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    shadow_len--;
                    reply.read_value = VALUE_W'(shadow_words[shadow_len]);
                end
            end
            OP_DELETE: begin
                if (shadow_len == 0) begin
                    reply.status = ST_EMPTY;
                end else if (pos >= shadow_len) begin
                    reply.status = ST_RANGE;
                end else begin
                    for (idx = pos; idx < shadow_len - 1; idx++) begin
                        shadow_words[idx] = shadow_words[idx+1];
                    end
                    shadow_len--;
                end
            end
            OP_REMOVE: begin
                kept = 0;
                for (idx = 0; idx < shadow_len; idx++) begin
                    if (shadow_words[idx] !== word) begin
                        shadow_words[kept] = shadow_words[idx];
                        kept++;
                    end
                end
                shadow_len = kept;
            end
            OP_FIND: begin
                for (idx = 0; idx < shadow_len && !reply.hit; idx++) begin
                    if (shadow_words[idx] === word) begin
                        reply.hit         = 1'b1;
                        reply.found_index = FIDX_W'(idx);
                    end
                end
            end
            OP_READ: begin
                if (shadow_len == 0) begin
                    reply.status = ST_EMPTY;
                end else if (pos >= shadow_len) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.read_value = VALUE_W'(shadow_words[pos]);
                end
            end
            default: begin
            end
        endcase
        reply.entry_count = ECNT_W'(shadow_len);
        return reply;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, actual %0h", field, want_v, got_v);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            due_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_replies.size() == 0) begin
                    $error("output transfer arrived with no result expected");
                    mismatch_total++;
                end else begin
                    oldest_reply = due_replies.pop_front();
                    check_field("read_value", 32'(oldest_reply.read_value),
                                32'(i_out_data.read_value));
                    check_field("found_index", 32'(oldest_reply.found_index),
                                32'(i_out_data.found_index));
                    check_field("hit", 32'(oldest_reply.hit), 32'(i_out_data.hit));
                    check_field("entry_count", 32'(oldest_reply.entry_count),
                                32'(i_out_data.entry_count));
                    check_field("status", 32'(oldest_reply.status),
                                32'(i_out_data.status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due_replies.push_back(apply_list_op(i_in_data));
            end
        end
        o_results_due <= due_replies.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the shifting list table bench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import slt_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int TAIL_CYCLES   = 2 * DEPTH + 8;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_ITEMS   = 62;

    localparam logic [MODE_W-1:0]  OP_NOP   = 3'd7;
    localparam logic [VALUE_W-1:0] DUP_WORD = 32'h0000_5A5A;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;

    int fail_total;
    int results_due;
    int idle_cycles = 0;
    bit in_gaps_on;
    bit out_gaps_on;
    bit hold_request;

    logic [VALUE_W-1:0] value_pool [8];

    shifting_list_table_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    list_table_checker u_list_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_data     (in_data),
        .i_in_stall    (in_stall),
        .i_out_valid   (out_valid),
        .i_out_data    (out_data),
        .i_out_stall   (out_stall),
        .o_fail_count  (fail_total),
        .o_results_due (results_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item random_op(input int grow_pct);
        t_in_item op;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < grow_pct) begin
            op.mode = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20) op.mode = OP_POP;
            else if (pick < 40) op.mode = OP_DELETE;
            else if (pick < 52) op.mode = OP_REMOVE;
            else if (pick < 75) op.mode = OP_FIND;
            else if (pick < 97) op.mode = OP_READ;
            else op.mode = OP_NOP;
        end
        op.position = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(17, 31))
                                                  : POS_W'($urandom_range(0, 16));
        op.item_value = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
                                                    : value_pool[$urandom_range(0, 7)];
        return op;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (in_gaps_on && $urandom_range(0, 99) < 30) begin
            gap = idle_length();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [MODE_W-1:0] mode, input int pos,
                           input logic [VALUE_W-1:0] value);
        t_in_item item;
        item.mode       = mode;
        item.position   = POS_W'(pos);
        item.item_value = value;
        send_item(item);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic run_directed();
        int k;
        // Every operation but push on the empty list, then an insert beyond the end.
        send_op(OP_POP, 0, '0);
        send_op(OP_DELETE, 0, '0);
        send_op(OP_READ, 0, '0);
        send_op(OP_FIND, 0, DUP_WORD);
        send_op(OP_REMOVE, 0, DUP_WORD);
        send_op(OP_NOP, 31, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 1, 32'h1234_5678);
        // Fill the list with prepends, appends, middle inserts and repeated words.
        send_op(OP_INSERT, 0, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 0, '0);
        send_op(OP_INSERT, 2, DUP_WORD);
        send_op(OP_INSERT, 1, 32'h8000_0001);
        send_op(OP_INSERT, 0, DUP_WORD);
        for (k = 5; k < DEPTH; k++) begin
            if (k % 2 == 1) send_op(OP_PUSH, 0, DUP_WORD);
            else send_op(OP_INSERT, k / 2, VALUE_W'($urandom));
        end
        // A full list is reported before a position out of range.
        send_op(OP_INSERT, 31, 32'h0000_0001);
        send_op(OP_PUSH, 0, 32'h0000_0002);
        send_op(OP_READ, DEPTH, '0);
        send_op(OP_READ, DEPTH - 1, '0);
        send_op(OP_DELETE, DEPTH, '0);
        send_op(OP_FIND, 0, DUP_WORD);
        send_op(OP_REMOVE, 0, DUP_WORD);
        send_op(OP_FIND, 0, DUP_WORD);
        send_op(OP_POP, 0, '0);
    endtask

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (out_gaps_on && $urandom_range(0, 99) < 25) begin
                    stall_left = idle_length();
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("shifting_list_table_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int grow;
        int k;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        in_gaps_on   = 1'b0;
        out_gaps_on  = 1'b0;
        hold_request = 1'b0;
        value_pool[0] = '0;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = DUP_WORD;
        for (k = 3; k < 8; k++) begin
            value_pool[k] = VALUE_W'($urandom);
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n       <= 1'b1;
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        run_directed();
        drain_results();
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 2))
                0:       grow = 70;
                1:       grow = 40;
                default: grow = 20;
            endcase
            in_gaps_on  = ($urandom_range(0, 3) != 0);
            out_gaps_on = ($urandom_range(0, 3) != 0);
            // The receiver holds off while the sender keeps offering, so the block backs up.
            if (phase == 4 || phase == 17) begin
                in_gaps_on   = 1'b0;
                hold_request = 1'b1;
            end
            repeat (PHASE_ITEMS) send_item(random_op(grow));
            if (phase % 4 == 3) drain_results();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_total == 0) begin
            $display("shifting_list_table_unit regression: pass");
        end else begin
            $display("shifting_list_table_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/slt_ctrl.sv
rtl/slt_out_reg.sv
rtl/shifting_list_table_unit.sv
bench/list_table_checker.sv
bench/testbench.sv
